[rtl/polled_telemetry_frame_receiver_core_macros.svh]
// Assertion helpers for the telemetry frame receiver.
`ifndef POLLED_TELEMETRY_FRAME_RECEIVER_CORE_MACROS_SVH
`define POLLED_TELEMETRY_FRAME_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define PTFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptfr assertion failed");
// Next-cycle implication, checked out of reset.
`define PTFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptfr assertion failed");
`else
`define PTFR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PTFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/ptfr_pkg.sv]
`default_nettype none

package ptfr_pkg;

  localparam int PayloadBytes = 7;

  // Configuration register indexes
  localparam logic [2:0] CFG_USE_CHECKSUM = 3'd0;
  localparam logic [2:0] CFG_START_BYTE   = 3'd1;
  localparam logic [2:0] CFG_ESCAPE_BYTE  = 3'd2;
  localparam logic [2:0] CFG_ESCAPE_MASK  = 3'd3;
  localparam logic [2:0] CFG_POLL_ID      = 3'd4;
  localparam logic [2:0] CFG_DATA_ID      = 3'd5;

  localparam logic [7:0] SUM_GOOD = 8'hFF;

  typedef struct packed {
    logic        frame_valid;
    logic [7:0]  frame_kind;
    logic [15:0] value_ident;
    logic [31:0] value_data;
    logic        clear_to_send;
  } res_t;

endpackage

`default_nettype wire

[rtl/polled_telemetry_frame_receiver_core.sv]
// Polled telemetry frame receiver.
// Input channel: one received byte (in_rx_byte) plus in_ready_to_send per
// transfer, taken when in_valid is high and in_stall is low.
// Result channel: one result per input byte, in order, offered on out_valid
// and taken when out_stall is low. out_frame_valid marks a byte that closed a
// good payload frame; the payload fields are zero otherwise.
// Configuration: cfg_valid/cfg_ready write cfg_data into register cfg_index;
// cfg_ready is always high. Write only while the block is idle.
// Each result is registered into the output buffer when its byte transfers.
// Throughput: one byte per cycle while in_stall is low; the whole decode step
// is combinational compare/add logic from frame state to the result register.
// A two-entry output buffer lets a byte transfer while a result waits; in_stall
// rises only when both entries hold results that the receiver has not taken.
// Reset: frame decoding skips until a start byte, the grant is low, the
// output buffer is empty and the registers take their reset values.
`default_nettype none

`include "polled_telemetry_frame_receiver_core_macros.svh"

module polled_telemetry_frame_receiver_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_ready_to_send,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_frame_valid,
  output logic [7:0]       out_frame_kind,
  output logic [15:0]      out_value_ident,
  output logic [31:0]      out_value_data,
  output logic             out_clear_to_send,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import ptfr_pkg::*;

  logic        use_cks_r;
  logic [7:0]  start_byte_r;
  logic [7:0]  escape_byte_r;
  logic [7:0]  escape_mask_r;
  logic [7:0]  poll_id_r;
  logic [7:0]  data_id_r;

  logic [7:0]  store_r [PayloadBytes];
  logic [7:0]  store_nxt [PayloadBytes];
  logic [2:0]  count_r, count_nxt;
  logic        skip_r, skip_nxt;
  logic        await_r, await_nxt;
  logic        unesc_r, unesc_nxt;
  logic [10:0] sum_r, sum_nxt;
  logic        grant_r, grant_nxt;

  logic [7:0]  c_unesc;
  logic [10:0] sum_add;
  logic [8:0]  sum_fold;
  logic        frame_ok;
  res_t        res;

  res_t        head_r, skid_r;
  logic        head_vld_r, skid_vld_r;
  logic        in_accept, out_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_accept = in_valid && !in_stall;
  assign out_pop   = head_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_cks_r     <= 1'b1;
      start_byte_r  <= 8'd126;
      escape_byte_r <= 8'd125;
      escape_mask_r <= 8'd32;
      poll_id_r     <= 8'd27;
      data_id_r     <= 8'd13;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_USE_CHECKSUM: use_cks_r     <= cfg_data[0];
        CFG_START_BYTE:   start_byte_r  <= cfg_data;
        CFG_ESCAPE_BYTE:  escape_byte_r <= cfg_data;
        CFG_ESCAPE_MASK:  escape_mask_r <= cfg_data;
        CFG_POLL_ID:      poll_id_r     <= cfg_data;
        CFG_DATA_ID:      data_id_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign c_unesc  = unesc_r ? (in_rx_byte ^ escape_mask_r) : in_rx_byte;
  assign sum_add  = sum_r + {3'b000, c_unesc};
  assign sum_fold = {1'b0, sum_add[7:0]} + {6'b000000, sum_add[10:8]};

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    skip_nxt  = skip_r;
    await_nxt = await_r;
    unesc_nxt = unesc_r;
    sum_nxt   = sum_r;
    grant_nxt = grant_r;
    frame_ok  = 1'b0;
    if (in_rx_byte == start_byte_r) begin
      // start byte wins, even after an escape; the escape flag is kept
      grant_nxt = 1'b0;
      count_nxt = 3'd0;
      await_nxt = 1'b1;
      skip_nxt  = 1'b0;
    end else if (!skip_r) begin
      if (await_r) begin
        await_nxt = 1'b0;
        if (in_rx_byte == poll_id_r && in_ready_to_send) begin
          grant_nxt = 1'b1;
          skip_nxt  = 1'b1;
        end else if (in_rx_byte == data_id_r) begin
          sum_nxt = 11'd0;
        end else begin
          skip_nxt = 1'b1;
        end
      end else if (in_rx_byte == escape_byte_r) begin
        unesc_nxt = 1'b1;
      end else begin
        unesc_nxt = 1'b0;
        if (count_r != 3'(PayloadBytes)) begin
          store_nxt[count_r] = c_unesc;
          count_nxt          = count_r + 3'd1;
          sum_nxt            = sum_add;
          if (!use_cks_r && count_r == 3'(PayloadBytes - 1)) begin
            skip_nxt = 1'b1;
            frame_ok = 1'b1;
          end
        end else begin
          // checksum byte: add, fold once, compare
          skip_nxt = 1'b1;
          sum_nxt  = {2'b00, sum_fold};
          frame_ok = (sum_fold == {1'b0, SUM_GOOD});
        end
      end
    end
  end

  always_comb begin
    res.frame_valid   = frame_ok;
    res.clear_to_send = grant_nxt;
    if (frame_ok) begin
      res.frame_kind  = store_nxt[0];
      res.value_ident = {store_nxt[2], store_nxt[1]};
      res.value_data  = {store_nxt[6], store_nxt[5], store_nxt[4], store_nxt[3]};
    end else begin
      res.frame_kind  = 8'd0;
      res.value_ident = 16'd0;
      res.value_data  = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      store_r <= store_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
      skip_r  <= 1'b1;
      await_r <= 1'b0;
      unesc_r <= 1'b0;
      sum_r   <= 11'd0;
      grant_r <= 1'b0;
    end else if (in_accept) begin
      count_r <= count_nxt;
      skip_r  <= skip_nxt;
      await_r <= await_nxt;
      unesc_r <= unesc_nxt;
      sum_r   <= sum_nxt;
      grant_r <= grant_nxt;
    end
  end

  // two-entry output buffer: head drives the port, skid holds the overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_pop) begin
          skid_vld_r <= 1'b0;
        end
      end else if (head_vld_r) begin
        if (in_accept && !out_pop) begin
          skid_vld_r <= 1'b1;
        end else if (!in_accept && out_pop) begin
          head_vld_r <= 1'b0;
        end
      end else if (in_accept) begin
        head_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_pop) begin
        head_r <= skid_r;
      end
    end else if (in_accept) begin
      if (!head_vld_r || out_pop) begin
        head_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid         = head_vld_r;
  assign out_frame_valid   = head_r.frame_valid;
  assign out_frame_kind    = head_r.frame_kind;
  assign out_value_ident   = head_r.value_ident;
  assign out_value_data    = head_r.value_data;
  assign out_clear_to_send = head_r.clear_to_send;

  `PTFR_ASSERT_NOW(a_skid_needs_head, clk, rst_n, skid_vld_r, head_vld_r)
  `PTFR_ASSERT_NEXT(a_transfer_shows, clk, rst_n, in_accept, out_valid)
  `PTFR_ASSERT_NOW(a_bad_frame_zero, clk, rst_n, out_valid && !out_frame_valid,
    out_frame_kind == 8'd0 && out_value_ident == 16'd0 && out_value_data == 32'd0)

endmodule

`default_nettype wire
